### rtl/core/pbu_pkg.sv
// shared constants, types and helpers for the rgba pixel blend unit
package pbu_pkg;

  localparam int RATE_FRAC_BITS = 16;
  localparam int RATE_W         = 17;
  localparam int MODE_W         = 5;

  // register indexes
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_RATE = 1'b1;

  // reset values
  localparam logic [MODE_W-1:0] MODE_RESET = 5'd19;
  localparam logic [RATE_W-1:0] RATE_RESET = 17'd65536;

  // blend mode codes
  localparam logic [MODE_W-1:0] M_SQRT      = 5'd0;
  localparam logic [MODE_W-1:0] M_LINEAR    = 5'd1;
  localparam logic [MODE_W-1:0] M_SW_KEEP   = 5'd2;
  localparam logic [MODE_W-1:0] M_ADD       = 5'd3;
  localparam logic [MODE_W-1:0] M_DW_KEEP   = 5'd4;
  localparam logic [MODE_W-1:0] M_DNB_KEEP  = 5'd5;
  localparam logic [MODE_W-1:0] M_SNB_KEEP  = 5'd6;
  localparam logic [MODE_W-1:0] M_DW_COPY   = 5'd7;
  localparam logic [MODE_W-1:0] M_SW_COPY   = 5'd8;
  localparam logic [MODE_W-1:0] M_DNB_COPY  = 5'd9;
  localparam logic [MODE_W-1:0] M_SNB_COPY  = 5'd10;
  localparam logic [MODE_W-1:0] M_DAO_KEEP  = 5'd11;
  localparam logic [MODE_W-1:0] M_SAF_KEEP  = 5'd12;
  localparam logic [MODE_W-1:0] M_SAO_COPY  = 5'd13;
  localparam logic [MODE_W-1:0] M_DAF_COPY  = 5'd14;
  localparam logic [MODE_W-1:0] M_MAX       = 5'd15;
  localparam logic [MODE_W-1:0] M_MIN       = 5'd16;
  localparam logic [MODE_W-1:0] M_MAX_ALPHA = 5'd17;
  localparam logic [MODE_W-1:0] M_MIN_ALPHA = 5'd18;
  localparam logic [MODE_W-1:0] M_SCREEN    = 5'd20;

  // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for any 16 bit x
  localparam logic [15:0] RECIP_255   = 16'h8081;
  localparam int          RECIP_SHIFT = 23;

  // per channel results, all aligned to the last pipeline stage
  typedef struct packed {
    logic [7:0] s;
    logic [7:0] d;
    logic [7:0] sqrt;
    logic [7:0] lin;
    logic [7:0] mul;
    logic [7:0] scr;
    logic [7:0] addc;
    logic [7:0] adda;
  } pbu_res_t;

  // one restoring square root step
  function automatic logic [8:0] sqrt_step(input logic [8:0] n, input logic [8:0] b,
                                           input logic [15:0] p);
    logic [8:0]  t;
    logic [17:0] sq;
    t  = n | b;
    sq = 18'(t) * 18'(t);
    return (sq <= 18'(p)) ? t : n;
  endfunction

  // clamp to 0..255
  function automatic logic [7:0] sat8(input logic [27:0] v);
    return (v > 28'd255) ? 8'd255 : v[7:0];
  endfunction

endpackage

### rtl/core/pbu_chan.sv
// five stage arithmetic pipeline for one color channel
module pbu_chan import pbu_pkg::*; (
  input  logic              clk,
  input  logic [7:0]        s,
  input  logic [7:0]        d,
  input  logic [7:0]        sa,
  input  logic [7:0]        da,
  input  logic [RATE_W-1:0] rate,
  output pbu_res_t          res
);

  localparam int LIN_W = RATE_FRAC_BITS + 14;
  localparam int WIDE  = 48;
  localparam logic [WIDE-1:0] HALF = WIDE'(1) << (RATE_FRAC_BITS - 1);

  // stage 1
  logic [7:0]         s1, d1, da1;
  logic [15:0]        p1, ssa1, dda1, mulx1, scrx1;
  logic signed [26:0] lin1;
  logic [24:0]        a1;
  // stage 2
  logic [7:0]         s2, d2, lin2, adda2;
  logic [15:0]        p2;
  logic [8:0]         n2;
  logic [WIDE-1:0]    cnum2;
  logic [31:0]        mul2, scr2;
  // stage 3
  logic [7:0]         s3, d3, lin3, adda3, mul3, scr3;
  logic [15:0]        p3, y3;
  logic [8:0]         n3;
  logic               sat3;
  // stage 4
  logic [7:0]         s4, d4, lin4, adda4, mul4, scr4;
  logic [15:0]        p4;
  logic [8:0]         n4;
  logic               sat4;
  logic [31:0]        cq4;

  // combinational terms for stages 2, 3 and 5
  logic signed [LIN_W-1:0] lin_num;
  logic [WIDE-1:0]         a_w, da_sh, a_rnd;
  logic [WIDE-1:0]         y_w;
  logic [17:0]             n4_sq;

  always_comb begin
    lin_num = $signed({{(LIN_W-8-RATE_FRAC_BITS){1'b0}}, d1, {RATE_FRAC_BITS{1'b0}}})
            + LIN_W'(lin1) + $signed(LIN_W'(HALF));
    a_w     = WIDE'(a1);
    da_sh   = WIDE'(da1) << RATE_FRAC_BITS;
    a_rnd   = (a_w + HALF) >> RATE_FRAC_BITS;
    y_w     = cnum2 >> RATE_FRAC_BITS;
    n4_sq   = 18'(n4) * 18'(n4) + 18'(n4);
  end

  always_ff @(posedge clk) begin
    // stage 1: products
    s1    <= s;
    d1    <= d;
    da1   <= da;
    p1    <= 16'(s) * 16'(d);
    ssa1  <= 16'(s) * 16'(sa);
    dda1  <= 16'(d) * 16'(da);
    mulx1 <= 16'(s) * 16'(d) + 16'd127;
    scrx1 <= 16'(8'd255 - s) * 16'(8'd255 - d) + 16'd127;
    lin1  <= $signed({1'b0, rate}) * ($signed({1'b0, s}) - $signed({1'b0, d}));
    a1    <= 25'(rate) * 25'(sa);

    // stage 2: rate products, linear result, alpha add, first root bits
    s2    <= s1;
    d2    <= d1;
    p2    <= p1;
    cnum2 <= WIDE'(rate) * WIDE'(ssa1) + (WIDE'(dda1) << RATE_FRAC_BITS)
           + (WIDE'(255) << (RATE_FRAC_BITS - 1));
    mul2  <= 32'(mulx1) * 32'(RECIP_255);
    scr2  <= 32'(scrx1) * 32'(RECIP_255);
    if (lin_num < 0) begin
      lin2 <= 8'd0;
    end else begin
      lin2 <= sat8(28'(lin_num >>> RATE_FRAC_BITS));
    end
    adda2 <= (a_w > da_sh) ? sat8(28'(a_rnd)) : da1;
    n2    <= sqrt_step(sqrt_step(sqrt_step(9'd0, 9'd256, p1), 9'd128, p1), 9'd64, p1);

    // stage 3: scale down, divide by 255 for multiply and screen
    s3    <= s2;
    d3    <= d2;
    p3    <= p2;
    lin3  <= lin2;
    adda3 <= adda2;
    sat3  <= y_w >= WIDE'(65280);
    y3    <= y_w[15:0];
    mul3  <= mul2[RECIP_SHIFT+7:RECIP_SHIFT];
    scr3  <= 8'd255 - scr2[RECIP_SHIFT+7:RECIP_SHIFT];
    n3    <= sqrt_step(sqrt_step(sqrt_step(n2, 9'd32, p2), 9'd16, p2), 9'd8, p2);

    // stage 4: colour divide by 255, last root bits
    s4    <= s3;
    d4    <= d3;
    p4    <= p3;
    lin4  <= lin3;
    adda4 <= adda3;
    mul4  <= mul3;
    scr4  <= scr3;
    sat4  <= sat3;
    cq4   <= 32'(y3) * 32'(RECIP_255);
    n4    <= sqrt_step(sqrt_step(sqrt_step(n3, 9'd4, p3), 9'd2, p3), 9'd1, p3);

    // stage 5: rounding and saturation
    res.s    <= s4;
    res.d    <= d4;
    res.lin  <= lin4;
    res.adda <= adda4;
    res.mul  <= mul4;
    res.scr  <= scr4;
    res.addc <= sat4 ? 8'd255 : cq4[RECIP_SHIFT+7:RECIP_SHIFT];
    res.sqrt <= sat8(28'((18'(p4) > n4_sq) ? n4 + 9'd1 : n4));
  end

endmodule

### rtl/core/rgba_pixel_blend_unit.sv
// Pixel blend unit, pipelined, one pixel per clock.
// A transaction accepted with start passes the five arithmetic stages and the output
// register; done rises with the result on the outputs.
// Throughput: one pixel every cycle; busy is always low, the pipeline never stalls.
// Reset clears the valid bits and sets blend_mode to 19 and blend_rate to 65536.
module rgba_pixel_blend_unit import pbu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        src_red,
  input  logic [7:0]        src_green,
  input  logic [7:0]        src_blue,
  input  logic [7:0]        src_alpha,
  input  logic [7:0]        dst_red,
  input  logic [7:0]        dst_green,
  input  logic [7:0]        dst_blue,
  input  logic [7:0]        dst_alpha,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [RATE_W-1:0] wr_data,
  output logic              done,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha
);

  typedef enum logic [1:0] {ACT_KEEP, ACT_LIN, ACT_COPY} act_t;

  logic [MODE_W-1:0] blend_mode;
  logic [RATE_W-1:0] blend_rate;
  logic [4:0]        vld;
  pbu_res_t          res [4];
  logic [7:0]        src_in [4];
  logic [7:0]        dst_in [4];
  logic [7:0]        o [4];
  act_t              act;
  logic              src_white, dst_white, src_black, dst_black;

  assign busy = 1'b0;

  assign src_in[0] = src_red;
  assign src_in[1] = src_green;
  assign src_in[2] = src_blue;
  assign src_in[3] = src_alpha;
  assign dst_in[0] = dst_red;
  assign dst_in[1] = dst_green;
  assign dst_in[2] = dst_blue;
  assign dst_in[3] = dst_alpha;

  // config registers and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_RESET;
      blend_rate <= RATE_RESET;
      vld        <= '0;
      done       <= 1'b0;
    end else begin
      if (wr_en && wr_index == REG_MODE) blend_mode <= wr_data[MODE_W-1:0];
      if (wr_en && wr_index == REG_RATE) blend_rate <= wr_data;
      vld  <= {vld[3:0], start && !busy};
      done <= vld[4];
    end
  end

  // channel pipelines
  for (genvar i = 0; i < 4; i++) begin : g_chan
    pbu_chan u_chan (
      .clk  (clk),
      .s    (src_in[i]),
      .d    (dst_in[i]),
      .sa   (src_alpha),
      .da   (dst_alpha),
      .rate (blend_rate),
      .res  (res[i])
    );
  end

  // pixel tests on the last stage
  assign src_white = res[0].s == 8'd255 && res[1].s == 8'd255 && res[2].s == 8'd255;
  assign dst_white = res[0].d == 8'd255 && res[1].d == 8'd255 && res[2].d == 8'd255;
  assign src_black = res[0].s == 8'd0 && res[1].s == 8'd0 && res[2].s == 8'd0;
  assign dst_black = res[0].d == 8'd0 && res[1].d == 8'd0 && res[2].d == 8'd0;

  // action for conditional modes
  always_comb begin
    act = ACT_KEEP;
    unique case (blend_mode)
      M_LINEAR:    act = ACT_LIN;
      M_SW_KEEP:   act = src_white ? ACT_KEEP : ACT_LIN;
      M_DW_KEEP:   act = dst_white ? ACT_KEEP : ACT_LIN;
      M_DNB_KEEP:  act = (res[3].d != 8'd0 && !dst_black) ? ACT_LIN : ACT_KEEP;
      M_SNB_KEEP:  act = (res[3].s != 8'd0 && !src_black) ? ACT_LIN : ACT_KEEP;
      M_DW_COPY:   act = dst_white ? ACT_COPY : ACT_LIN;
      M_SW_COPY:   act = src_white ? ACT_COPY : ACT_LIN;
      M_DNB_COPY:  act = (res[3].d != 8'd0 && !dst_black) ? ACT_LIN : ACT_COPY;
      M_SNB_COPY:  act = (res[3].s != 8'd0 && !src_black) ? ACT_LIN : ACT_COPY;
      M_DAO_KEEP:  act = (res[3].d != 8'd255) ? ACT_LIN : ACT_KEEP;
      M_SAF_KEEP:  act = (res[3].s == 8'd255) ? ACT_LIN : ACT_KEEP;
      M_SAO_COPY:  act = (res[3].s != 8'd255) ? ACT_LIN : ACT_COPY;
      M_DAF_COPY:  act = (res[3].d == 8'd255) ? ACT_LIN : ACT_COPY;
      M_MAX_ALPHA: act = (res[3].s > res[3].d) ? ACT_COPY : ACT_KEEP;
      M_MIN_ALPHA: act = (res[3].s < res[3].d) ? ACT_COPY : ACT_KEEP;
      default:     act = ACT_KEEP;
    endcase
  end

  // result select per channel
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      case (blend_mode) inside
        M_SQRT:   o[i] = res[i].sqrt;
        M_ADD:    o[i] = (i == 3) ? res[3].adda : res[i].addc;
        M_MAX:    o[i] = (res[i].s > res[i].d) ? res[i].s : res[i].d;
        M_MIN:    o[i] = (res[i].s < res[i].d) ? res[i].s : res[i].d;
        M_SCREEN: o[i] = res[i].scr;
        M_LINEAR, M_SW_KEEP, M_DW_KEEP, M_DNB_KEEP, M_SNB_KEEP, M_DW_COPY, M_SW_COPY,
        M_DNB_COPY, M_SNB_COPY, M_DAO_KEEP, M_SAF_KEEP, M_SAO_COPY, M_DAF_COPY,
        M_MAX_ALPHA, M_MIN_ALPHA: begin
          case (act)
            ACT_LIN:  o[i] = res[i].lin;
            ACT_COPY: o[i] = res[i].s;
            default:  o[i] = res[i].d;
          endcase
        end
        default:  o[i] = res[i].mul;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    out_red   <= o[0];
    out_green <= o[1];
    out_blue  <= o[2];
    out_alpha <= o[3];
  end

endmodule

### rtl/core/pbu_checker.sv
// port level checks for the pixel blend unit, bound to the top level
module pbu_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // unit never holds off a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every accepted transaction gives a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("result missing");

  // no result without an earlier accepted transaction
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("unexpected result");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");

endmodule

bind rgba_pixel_blend_unit pbu_checker u_pbu_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

### verif/testbench.sv
// self-checking testbench for the rgba pixel blend unit: directed table, every mode, then random pixels
module testbench;
  import pbu_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [7:0] src_red = '0, src_green = '0, src_blue = '0, src_alpha = '0;
  logic [7:0] dst_red = '0, dst_green = '0, dst_blue = '0, dst_alpha = '0;
  logic wr_en = 1'b0;
  logic wr_index = REG_MODE;
  logic [RATE_W-1:0] wr_data = '0;
  logic done;
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  typedef logic [7:0] chan4_t [4];

  typedef struct {
    logic [7:0] px [8];
    bit         typed;
    logic [7:0] want [4];
  } stim_row_t;

  logic [31:0] pixel_queue [$];
  int errors = 0;
  int unsigned cycle_count = 0;
  logic [MODE_W-1:0] cur_mode;
  logic [RATE_W-1:0] cur_rate;

  rgba_pixel_blend_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .src_red(src_red), .src_green(src_green), .src_blue(src_blue), .src_alpha(src_alpha),
    .dst_red(dst_red), .dst_green(dst_green), .dst_blue(dst_blue), .dst_alpha(dst_alpha),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .done(done), .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // blend math
  function automatic logic [7:0] clamp8(longint v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  function automatic logic [7:0] geo_root(longint s, longint d);
    longint p, n, t, b;
    p = s * d;
    n = 0;
    for (b = 256; b != 0; b = b >> 1) begin
      t = n + b;
      if (t * t <= p) n = t;
    end
    if (p > n * n + n) n++;
    return clamp8(n);
  endfunction

  function automatic logic [7:0] mix_rate(longint s, longint d);
    longint one, num;
    one = longint'(1) << RATE_FRAC_BITS;
    num = one * d + longint'(cur_rate) * (s - d) + one / 2;
    if (num < 0) return 8'd0;
    return clamp8(num >>> RATE_FRAC_BITS);
  endfunction

  function automatic logic [7:0] mul255(longint s, longint d);
    return 8'((s * d + 127) / 255);
  endfunction

  function automatic chan4_t blend_pixel(logic [7:0] px [8]);
    chan4_t o;
    longint s [4], d [4];
    longint one, a;
    bit sw, dw, sb, db;
    int act;
    one = longint'(1) << RATE_FRAC_BITS;
    for (int i = 0; i < 4; i++) begin
      s[i] = px[i];
      d[i] = px[4 + i];
      o[i] = px[4 + i];
    end
    sw = s[0] == 255 && s[1] == 255 && s[2] == 255;
    dw = d[0] == 255 && d[1] == 255 && d[2] == 255;
    sb = s[0] == 0 && s[1] == 0 && s[2] == 0;
    db = d[0] == 0 && d[1] == 0 && d[2] == 0;
    act = 0;
    case (cur_mode)
      M_SQRT:      for (int i = 0; i < 4; i++) o[i] = geo_root(s[i], d[i]);
      M_LINEAR:    act = 1;
      M_SW_KEEP:   act = sw ? 0 : 1;
      M_ADD: begin
        for (int i = 0; i < 3; i++)
          o[i] = clamp8((longint'(cur_rate) * s[i] * s[3] + one * d[i] * d[3]
                         + one * 255 / 2) / (one * 255));
        a = longint'(cur_rate) * s[3];
        o[3] = (a > d[3] * one) ? clamp8((a + one / 2) >>> RATE_FRAC_BITS) : 8'(d[3]);
      end
      M_DW_KEEP:   act = dw ? 0 : 1;
      M_DNB_KEEP:  act = (d[3] != 0 && !db) ? 1 : 0;
      M_SNB_KEEP:  act = (s[3] != 0 && !sb) ? 1 : 0;
      M_DW_COPY:   act = dw ? 2 : 1;
      M_SW_COPY:   act = sw ? 2 : 1;
      M_DNB_COPY:  act = (d[3] != 0 && !db) ? 1 : 2;
      M_SNB_COPY:  act = (s[3] != 0 && !sb) ? 1 : 2;
      M_DAO_KEEP:  act = d[3] != 255 ? 1 : 0;
      M_SAF_KEEP:  act = s[3] == 255 ? 1 : 0;
      M_SAO_COPY:  act = s[3] != 255 ? 1 : 2;
      M_DAF_COPY:  act = d[3] == 255 ? 1 : 2;
      M_MAX:       for (int i = 0; i < 4; i++) o[i] = 8'((s[i] > d[i]) ? s[i] : d[i]);
      M_MIN:       for (int i = 0; i < 4; i++) o[i] = 8'((s[i] < d[i]) ? s[i] : d[i]);
      M_MAX_ALPHA: act = s[3] > d[3] ? 2 : 0;
      M_MIN_ALPHA: act = s[3] < d[3] ? 2 : 0;
      M_SCREEN:    for (int i = 0; i < 4; i++) o[i] = 8'd255 - mul255(255 - s[i], 255 - d[i]);
      default:     for (int i = 0; i < 4; i++) o[i] = mul255(s[i], d[i]);
    endcase
    if (act == 1) for (int i = 0; i < 4; i++) o[i] = mix_rate(s[i], d[i]);
    else if (act == 2) for (int i = 0; i < 4; i++) o[i] = 8'(s[i]);
    return o;
  endfunction

  // compare each done strobe with the oldest expected pixel
  always @(posedge clk) begin
    logic [31:0] w;
    if (!rst && done) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected result %h %h %h %h", out_red, out_green, out_blue, out_alpha);
        errors++;
      end else begin
        w = pixel_queue.pop_front();
        if (out_red !== w[31:24]) begin
          $error("out_red expected %0d actual %0d", w[31:24], out_red); errors++;
        end
        if (out_green !== w[23:16]) begin
          $error("out_green expected %0d actual %0d", w[23:16], out_green); errors++;
        end
        if (out_blue !== w[15:8]) begin
          $error("out_blue expected %0d actual %0d", w[15:8], out_blue); errors++;
        end
        if (out_alpha !== w[7:0]) begin
          $error("out_alpha expected %0d actual %0d", w[7:0], out_alpha); errors++;
        end
      end
    end
  end

  // idle length between transactions, mostly short, sometimes long
  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // one transaction; typed rows use the hand-written expected result
  task automatic send_pixel(logic [7:0] px [8], bit typed, logic [7:0] want [4]);
    chan4_t e;
    int n;
    if (typed) e = want;
    else e = blend_pixel(px);
    start <= 1'b1;
    {src_red, src_green, src_blue, src_alpha} <= {px[0], px[1], px[2], px[3]};
    {dst_red, dst_green, dst_blue, dst_alpha} <= {px[4], px[5], px[6], px[7]};
    @(posedge clk);
    while (busy) @(posedge clk);
    pixel_queue.insert(pixel_queue.size(), {e[0], e[1], e[2], e[3]});
    n = $urandom_range(0, 1) ? gap_len() : 0;
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [RATE_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_MODE) cur_mode = val[MODE_W-1:0];
    else cur_rate = val;
  endtask

  function automatic stim_row_t row(logic [63:0] p, bit typed, logic [31:0] w);
    stim_row_t r;
    for (int i = 0; i < 8; i++) r.px[i] = p[63 - 8*i -: 8];
    r.typed = typed;
    for (int i = 0; i < 4; i++) r.want[i] = w[31 - 8*i -: 8];
    return r;
  endfunction

  function automatic logic [7:0] rnd_chan();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    stim_row_t tbl [$];
    logic [7:0] px [8];
    logic [7:0] none [4];
    logic [RATE_W-1:0] rates [5];
    logic [7:0] c;
    for (int i = 0; i < 4; i++) none[i] = '0;
    cur_mode = MODE_RESET;
    cur_rate = RATE_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset mode is multiply
    tbl.insert(tbl.size(), row(64'hFFFFFFFF_FFFFFFFF, 1, 32'hFFFFFFFF));
    tbl.insert(tbl.size(), row(64'h00000000_FFFFFFFF, 1, 32'h00000000));
    tbl.insert(tbl.size(), row(64'hFF80017F_01FF8080, 0, 0));
    foreach (tbl[k]) send_pixel(tbl[k].px, tbl[k].typed, tbl[k].want);
    drain();

    // every mode with white, black, alpha extremes
    for (int m = 0; m < 32; m += (m < 21 ? 1 : 5)) begin
      write_reg(REG_MODE, RATE_W'(m));
      tbl.delete();
      tbl.insert(tbl.size(), row(64'hFFFFFF00_000000FF, 0, 0));
      tbl.insert(tbl.size(), row(64'h000000FF_FFFFFF00, 0, 0));
      tbl.insert(tbl.size(), row(64'h12345678_9ABCDEF0, 0, 0));
      foreach (tbl[k]) send_pixel(tbl[k].px, tbl[k].typed, tbl[k].want);
      drain();
    end

    // random phases across rates, extremes included
    rates = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd1};
    for (int ph = 0; ph < 20; ph++) begin
      write_reg(REG_RATE, (ph < 5) ? rates[ph] : RATE_W'($urandom));
      write_reg(REG_MODE, RATE_W'((ph < 5) ? M_ADD : $urandom_range(0, 31)));
      repeat (16) begin
        c = rnd_chan();
        for (int i = 0; i < 8; i++) px[i] = rnd_chan();
        // sometimes force an equal triplet, often white or black
        if ($urandom_range(0, 3) == 0) for (int i = 0; i < 3; i++) px[i] = c;
        if ($urandom_range(0, 3) == 0) for (int i = 4; i < 7; i++) px[i] = c;
        send_pixel(px, 0, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
